FILE: rtl/ialu_pkg.sv
// ialu_pkg: shared constants, operation codes and stage types for the integer alu
// no dependencies
package ialu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CMD_WIDTH  = 4;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [CMD_WIDTH-1:0]  cmd_t;

    localparam cmd_t OP_ADD  = 4'd0;
    localparam cmd_t OP_SUB  = 4'd1;
    localparam cmd_t OP_POS  = 4'd2;
    localparam cmd_t OP_NEG  = 4'd3;
    localparam cmd_t OP_ABS  = 4'd4;
    localparam cmd_t OP_MUL  = 4'd5;
    localparam cmd_t OP_DIV  = 4'd6;
    localparam cmd_t OP_MOD  = 4'd7;
    localparam cmd_t OP_REM  = 4'd8;
    localparam cmd_t OP_AND  = 4'd9;
    localparam cmd_t OP_OR   = 4'd10;
    localparam cmd_t OP_NAND = 4'd11;
    localparam cmd_t OP_NOR  = 4'd12;
    localparam cmd_t OP_XOR  = 4'd13;
    localparam cmd_t OP_XNOR = 4'd14;
    localparam cmd_t OP_NOT  = 4'd15;

    // per-item context carried beside the divider stages
    typedef struct packed {
        cmd_t  cmd;
        word_t b;
        logic  neg_a;
        logic  neg_b;
        logic  dz;
        word_t simple;
    } ctx_t;

endpackage

FILE: rtl/ialu_if.sv
// ialu_if: valid/ready channel interfaces for input and result transactions
// depends on ialu_pkg
interface ialu_in_if;
    import ialu_pkg::*;
    logic  valid;
    logic  ready;
    cmd_t  cmd;
    word_t left_operand;
    word_t right_operand;
    modport source (output valid, output cmd, output left_operand, output right_operand,
                    input ready);
    modport sink (input valid, input cmd, input left_operand, input right_operand,
                  output ready);
endinterface

interface ialu_out_if;
    import ialu_pkg::*;
    logic  valid;
    logic  ready;
    word_t result_value;
    logic  divide_by_zero;
    modport source (output valid, output result_value, output divide_by_zero, input ready);
    modport sink (input valid, input result_value, input divide_by_zero, output ready);
endinterface

FILE: rtl/vhdl_integer_alu.sv
// vhdl_integer_alu: top level, pipelined integer alu with truncating divide, rem and mod
// depends on ialu_pkg, ialu_if, ialu_div_stage
//
// Pipelined 32-bit signed alu. One transaction is accepted every cycle unless a result
// is stalled at the output; the latency is set by the divider, a chain
// of register stages that each resolve two quotient bits. Every operation runs
// through the same chain so results leave in order. The whole pipe advances only when
// the output register is free or being emptied, so a stalled result holds everything
// behind it and nothing is lost or repeated. Stage 0 registers the operands and forms
// the magnitudes; the middle stages divide; the multiplier product is registered in
// stage 0 and held in the context; the last stage forms div, rem and mod and the final
// result. A zero divisor on div, rem or mod gives result 0 with divide_by_zero set.
module vhdl_integer_alu
    import ialu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ialu_in_if.sink    in_ch,
    ialu_out_if.source out_ch
);
    localparam int NSTG = DATA_WIDTH / 2;

    logic advance;
    // valid bits: stage 0, divider stages 1..NSTG
    logic [NSTG:0] vld_reg;
    ctx_t          ctx_reg [NSTG+1];
    word_t         rem_reg [NSTG+1];
    word_t         quo_reg [NSTG+1];
    word_t         dvs_reg [NSTG+1];
    logic          out_valid_reg;
    word_t         out_res_reg;
    logic          out_dz_reg;

    // pipe moves when the output slot is empty or being taken
    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = advance;

    // stage 0 front end: simple ops and magnitudes
    word_t a, b, mag_a, mag_b, simple_v;
    logic  na, nb;
    always_comb
    begin
        a     = in_ch.left_operand;
        b     = in_ch.right_operand;
        na    = a[DATA_WIDTH-1];
        nb    = b[DATA_WIDTH-1];
        mag_a = na ? (~a + word_t'(1)) : a;
        mag_b = nb ? (~b + word_t'(1)) : b;
        case (in_ch.cmd)
            OP_ADD:  simple_v = a + b;
            OP_SUB:  simple_v = a - b;
            OP_POS:  simple_v = a;
            OP_NEG:  simple_v = ~a + word_t'(1);
            OP_ABS:  simple_v = mag_a;
            OP_MUL:  simple_v = word_t'(a * b);
            OP_AND:  simple_v = a & b;
            OP_OR:   simple_v = a | b;
            OP_NAND: simple_v = word_t'(1) - (a & b);
            OP_NOR:  simple_v = word_t'(1) - (a | b);
            OP_XOR:  simple_v = word_t'(a != b);
            OP_XNOR: simple_v = word_t'(a == b);
            OP_NOT:  simple_v = word_t'(a == '0);
            default: simple_v = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[NSTG-1:0], in_ch.valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctx_reg[0] <= '{cmd: in_ch.cmd, b: b, neg_a: na, neg_b: nb,
                            dz: (b == '0), simple: simple_v};
            rem_reg[0] <= '0;
            quo_reg[0] <= mag_a;
            dvs_reg[0] <= mag_b;
        end
    end

    // divider chain, two steps per register stage
    for (genvar s = 0; s < NSTG; s++)
    begin : g_div
        word_t r1, q1, r2, q2;
        ialu_div_stage u_st_a (.rem_in(rem_reg[s]), .quo_in(quo_reg[s]), .div_in(dvs_reg[s]),
                               .rem_out(r1), .quo_out(q1));
        ialu_div_stage u_st_b (.rem_in(r1), .quo_in(q1), .div_in(dvs_reg[s]),
                               .rem_out(r2), .quo_out(q2));
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                ctx_reg[s+1] <= ctx_reg[s];
                rem_reg[s+1] <= r2;
                quo_reg[s+1] <= q2;
                dvs_reg[s+1] <= dvs_reg[s];
            end
        end
    end

    // final stage: sign fix-up and result select
    ctx_t  c;
    word_t q, r, rt, res_next;
    always_comb
    begin
        c  = ctx_reg[NSTG];
        q  = quo_reg[NSTG];
        r  = rem_reg[NSTG];
        rt = c.neg_a ? (~r + word_t'(1)) : r;
        case (c.cmd)
            OP_DIV:  res_next = (c.neg_a != c.neg_b) ? (~q + word_t'(1)) : q;
            OP_REM:  res_next = rt;
            OP_MOD:  res_next = (r == '0) ? '0 : ((c.neg_a != c.neg_b) ? rt + c.b : rt);
            default: res_next = c.simple;
        endcase
        if (c.dz && (c.cmd == OP_DIV || c.cmd == OP_MOD || c.cmd == OP_REM))
            res_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= vld_reg[NSTG];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
            out_dz_reg  <= c.dz && (c.cmd == OP_DIV || c.cmd == OP_MOD || c.cmd == OP_REM);
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.result_value   = out_res_reg;
    assign out_ch.divide_by_zero = out_dz_reg;

    // a stalled result must hold
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_res_reg))
        else $error("result changed under stall");
    // flag set implies a zero result
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_dz_reg |-> out_res_reg == '0)
        else $error("zero divisor with nonzero result");
    // pipe frozen when stalled
    a_frz: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(vld_reg))
        else $error("pipe moved under stall");
endmodule

FILE: rtl/ialu_div_stage.sv
// ialu_div_stage: one restoring-division step on unsigned magnitudes
// depends on ialu_pkg
module ialu_div_stage
    import ialu_pkg::*;
(
    input  word_t rem_in,
    input  word_t quo_in,
    input  word_t div_in,
    output word_t rem_out,
    output word_t quo_out
);
    logic [DATA_WIDTH:0] shifted;
    logic [DATA_WIDTH:0] diff;

    always_comb
    begin
        shifted = {rem_in, quo_in[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, div_in};
        if (!diff[DATA_WIDTH])
        begin
            rem_out = diff[DATA_WIDTH-1:0];
            quo_out = {quo_in[DATA_WIDTH-2:0], 1'b1};
        end
        else
        begin
            rem_out = shifted[DATA_WIDTH-1:0];
            quo_out = {quo_in[DATA_WIDTH-2:0], 1'b0};
        end
    end
endmodule

FILE: dv/tb_vhdl_integer_alu.sv
`timescale 1ns / 100ps
// tb_vhdl_integer_alu: self-checking testbench for the pipelined vhdl-style integer alu
// depends on ialu_pkg, ialu_if and vhdl_integer_alu from rtl
//
// a golden alu computes each expected result when the input transaction is accepted
// and queues it; a checker compares every accepted result, in order, with the oldest
// expected one. directed corner operands come first, then random phases that each use
// a different amount of sender idling and receiver stalling
module tb_vhdl_integer_alu;
    import ialu_pkg::*;

    localparam int    LATENCY     = DATA_WIDTH / 2 + 1;
    localparam int    CYCLE_LIMIT = 400000;
    localparam word_t MOST_NEG    = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam word_t MOST_POS    = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t ALL_ONES    = {DATA_WIDTH{1'b1}};

    typedef struct packed {
        word_t value;
        logic  dz;
    } alu_result_t;

    logic clk;
    logic rst_n;

    ialu_in_if  in_ch ();
    ialu_out_if out_ch ();

    vhdl_integer_alu u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // results still owed by the alu, oldest first
    alu_result_t pending_results[$];

    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned sent_count;
    int unsigned checked_count;
    int unsigned dz_count;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // magnitude of a two's complement word, wraps on the most negative value
    function automatic word_t magnitude(word_t x);
        return x[DATA_WIDTH-1] ? -x : x;
    endfunction

    // golden alu, vhdl semantics
    function automatic alu_result_t alu_golden(cmd_t op, word_t a, word_t b);
        alu_result_t r;
        word_t       ma;
        word_t       mb;
        word_t       quo;
        word_t       rmd;
        word_t       rem_signed;
        logic        na;
        logic        nb;
        na      = a[DATA_WIDTH-1];
        nb      = b[DATA_WIDTH-1];
        r.value = '0;
        r.dz    = 1'b0;
        case (op)
            OP_ADD:  r.value = a + b;
            OP_SUB:  r.value = a - b;
            OP_POS:  r.value = a;
            OP_NEG:  r.value = -a;
            OP_ABS:  r.value = magnitude(a);
            OP_MUL:  r.value = a * b;
            OP_DIV, OP_MOD, OP_REM:
            begin
                if (b == '0)
                begin
                    r.dz = 1'b1;
                end
                else
                begin
                    ma         = magnitude(a);
                    mb         = magnitude(b);
                    quo        = ma / mb;
                    rmd        = ma % mb;
                    rem_signed = na ? -rmd : rmd;
                    if (op == OP_DIV)
                        r.value = (na != nb) ? -quo : quo;
                    else if (op == OP_REM)
                        r.value = rem_signed;
                    else if (rmd == '0)
                        r.value = '0;
                    else
                        r.value = (na != nb) ? rem_signed + b : rem_signed;
                end
            end
            OP_AND:  r.value = a & b;
            OP_OR:   r.value = a | b;
            OP_NAND: r.value = word_t'(1) - (a & b);
            OP_NOR:  r.value = word_t'(1) - (a | b);
            OP_XOR:  r.value = word_t'(a != b);
            OP_XNOR: r.value = word_t'(a == b);
            default: r.value = word_t'(a == '0);
        endcase
        return r;
    endfunction

    // cycle counter, gives up on a hung pipe
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stall, ready updated once per edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // result checker, samples the handshake at the edge
    always @(posedge clk)
    begin
        alu_result_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            checked_count <= checked_count + 1;
            if (pending_results.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: value %h dz %b",
                             out_ch.result_value, out_ch.divide_by_zero);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (exp_r.dz)
                    dz_count <= dz_count + 1;
                if (out_ch.result_value !== exp_r.value
                    || out_ch.divide_by_zero !== exp_r.dz)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("mismatch at cycle %0d: expected %h dz %b, got %h dz %b",
                                 cycle_count, exp_r.value, exp_r.dz,
                                 out_ch.result_value, out_ch.divide_by_zero);
                end
            end
        end
    end

    // drives one input transaction, with a random idle gap first, and holds it until
    // accepted; the expected result is queued at the accepting edge
    task automatic send_op(cmd_t op, word_t a, word_t b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= op;
        in_ch.left_operand  <= a;
        in_ch.right_operand <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_results.push_back(alu_golden(op, a, b));
        sent_count++;
        // valid stays high unless the next call idles or the caller drops it
    endtask

    task automatic release_input();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // pressure point: hold off until the pipe has drained every result
    task automatic wait_drained();
        release_input();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // random operand biased toward the interesting edges
    function automatic word_t rand_operand();
        case ($urandom_range(9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return '0;
            3:       return word_t'($urandom_range(3)) - 1;
            4:       return word_t'($urandom_range(255)) - 128;
            default: return word_t'({$urandom, $urandom});
        endcase
    endfunction

    task automatic test_directed();
        word_t corner[6];
        corner = '{MOST_NEG, MOST_POS, '0, word_t'(1), ALL_ONES, word_t'(7)};
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // every operation on sign-mixed operands
        for (int op = 0; op < 16; op++)
            send_op(cmd_t'(op), word_t'(-7), word_t'(3));
        // most negative value through neg, abs, and divide family by -1
        send_op(OP_NEG, MOST_NEG, '0);
        send_op(OP_ABS, MOST_NEG, '0);
        send_op(OP_DIV, MOST_NEG, ALL_ONES);
        send_op(OP_MOD, MOST_NEG, ALL_ONES);
        send_op(OP_REM, MOST_NEG, ALL_ONES);
        // zero divisor for div, mod and rem
        send_op(OP_DIV, MOST_POS, '0);
        send_op(OP_MOD, word_t'(-5), '0);
        send_op(OP_REM, '0, '0);
        // mod with zero remainder and mixed signs
        send_op(OP_MOD, word_t'(-6), word_t'(3));
        wait_drained();
        // mod across the corner pairs, sign test included
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 6; j++)
                send_op(OP_MOD, corner[i], corner[j]);
        wait_drained();
    endtask

    task automatic test_random_phase(int unsigned n, int unsigned idle, int unsigned stall);
        sender_idle_pct    = idle;
        receiver_stall_pct = stall;
        for (int unsigned i = 0; i < n; i++)
            send_op(cmd_t'($urandom_range(15)), rand_operand(), rand_operand());
        wait_drained();
    endtask

    initial
    begin
        cycle_count        = 0;
        mismatch_count     = 0;
        sent_count         = 0;
        checked_count      = 0;
        dz_count           = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.cmd           = OP_ADD;
        in_ch.left_operand  = '0;
        in_ch.right_operand = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(190, 0, 0);
        test_random_phase(200, 84, 0);
        test_random_phase(200, 0, 84);
        test_random_phase(200, 6, 6);

        // let any stray result show up before the verdict
        repeat (LATENCY * 4) @(posedge clk);
        if (pending_results.size() != 0)
            mismatch_count = mismatch_count + pending_results.size();

        $display("%0d transactions sent, %0d results checked, %0d with divide by zero",
                 sent_count, checked_count, dz_count);
        $display("all sixteen operations, operand corners and four idle/stall mixes covered");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
